// File: src/ccas_pkg.sv
// shared types, codes and calendar helpers for the alarm clock timekeeper
`default_nettype none

package ccas_pkg;

  // input item kinds carried on tuser
  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_BUTTON   = 2'd1,
    ACT_SET_TIME = 2'd2,
    ACT_LAMP_OFF = 2'd3
  } action_t;

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_ADDR_W-1:0] REG_ALARM_ONE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALARM_TWO    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SUNRISE_DLY  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BL_FLOOR     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BL_CEILING   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_FADE_INC     = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SNOOZE_LEN   = 3'd7;

  // enable register bits
  localparam int EN_ALARM_ONE = 0;
  localparam int EN_ALARM_TWO = 1;
  localparam int EN_SUNRISE   = 2;

  localparam logic [11:0] MINUTES_PER_DAY = 12'd1440;

  // days in a month, no leap years, invalid months have 31 days
  function automatic logic [4:0] days_in(input logic [3:0] month);
    logic [4:0] days;
    case (month)
      4'd2:                       days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    days = 5'd30;
      default:                    days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

// File: src/clock_calendar_alarm_sunrise.sv
// alarm clock timekeeper with calendar, two alarms, sunrise lamp, backlight fade and snooze
//
// Usage:
//   s_axis carries one item per transaction: tuser holds the action (tick of 1/64 s,
//   button press, set time, lamp off), tdata holds the time values used by set time.
//   m_axis returns one result per input item: the full time and date plus the
//   backlight level, lamp level, ringing and snooze flags after that item.
//   The cfg port writes one register per cycle with cfg_we; no read-back.
// Latency and throughput:
//   a result appears in the cycle after its item is accepted; one item is taken
//   every cycle while the result register is empty or being read, set by the single
//   state update between the item and the result register.
// Reset:
//   rst (synchronous) loads 23:59:58 on day 1 month 1 year 2012, weekday 1,
//   clears backlight, lamp, ringing and snooze, and loads the register defaults.
// Stall:
//   while m_axis_tready is low the result is held and s_axis_tready drops
//   once the result register is full; no item is lost.
`default_nettype none

module clock_calendar_alarm_sunrise
  import ccas_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 64,
  parameter int LEVEL_COUNT      = 64,
  parameter int HOLD_TIME        = 5,
  localparam int LAMP_W  = $clog2(LEVEL_COUNT),
  localparam int OUT_BITS = 49 + LAMP_W,
  localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input item channel
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // new_hours, new_minutes, new_seconds, new_day, new_month, new_year, new_weekday
  input  wire logic [47:0]           s_axis_tdata,
  // action
  input  wire logic [1:0]            s_axis_tuser,
  // result channel
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // hours_now, minutes_now, seconds_now, day_now, month_now, year_now, weekday_now,
  // backlight_out, lamp_out, ringing_flag, snooze_flag
  output logic [OUT_W-1:0]           m_axis_tdata,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TICK_W = $clog2(TICKS_PER_SECOND);
  localparam int HOLD_W = $clog2(HOLD_TIME + 1);
  localparam logic [TICK_W:0] TICK_LIMIT = (TICK_W+1)'(TICKS_PER_SECOND);
  localparam logic [LAMP_W:0] LAMP_TOP   = (LAMP_W+1)'(LEVEL_COUNT - 1);
  localparam logic [HOLD_W-1:0] HOLD_LOAD = HOLD_W'(HOLD_TIME);

  // configuration registers
  logic [10:0] alarm_one_minute;
  logic [10:0] alarm_two_minute;
  logic [6:0]  sunrise_delay;
  logic [2:0]  enable_bits;
  logic [5:0]  backlight_floor;
  logic [5:0]  backlight_ceiling;
  logic [5:0]  fade_increment;
  logic [11:0] snooze_length;

  // timekeeping and control state
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [5:0]  sec_reg, sec_reg_next;
  logic [5:0]  min_reg, min_reg_next;
  logic [4:0]  hour_reg, hour_reg_next;
  logic [4:0]  day_reg, day_reg_next;
  logic [3:0]  month_reg, month_reg_next;
  logic [11:0] year_reg, year_reg_next;
  logic [2:0]  weekday_reg, weekday_reg_next;
  logic [5:0]  backlight_level, backlight_level_next;
  logic        fade_running, fade_running_next;
  logic        fade_downward, fade_downward_next;
  logic [HOLD_W-1:0] hold_seconds, hold_seconds_next;
  logic [LAMP_W-1:0] lamp_level, lamp_level_next;
  logic        sunrise_running, sunrise_running_next;
  logic [6:0]  sunrise_seconds, sunrise_seconds_next;
  logic        ring_active, ring_active_next;
  logic        snooze_active, snooze_active_next;
  logic [11:0] snooze_seconds, snooze_seconds_next;

  logic        in_fire;
  action_t     in_action;

  // input fields
  logic [4:0]  new_hours;
  logic [5:0]  new_minutes;
  logic [5:0]  new_seconds;
  logic [4:0]  new_day;
  logic [3:0]  new_month;
  logic [11:0] new_year;
  logic [2:0]  new_weekday;

  // intermediate values of the update
  logic [TICK_W:0]   tick_sum;
  logic signed [7:0] fade_raw;
  logic signed [7:0] fade_hi;
  logic signed [7:0] fade_lo;
  logic              fade_stop;
  logic [6:0]        sec_sum;
  logic [6:0]        min_sum;
  logic [5:0]        hour_sum;
  logic [5:0]        day_sum;
  logic [4:0]        month_sum;
  logic [6:0]        sunrise_sum;
  logic [LAMP_W:0]   lamp_sum;
  logic [10:0]       now_minute;
  logic [11:0]       alarm_one_day;
  logic [11:0]       start_raw;
  logic [11:0]       sunrise_start;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_action     = action_t'(s_axis_tuser);

  assign new_hours   = s_axis_tdata[4:0];
  assign new_minutes = s_axis_tdata[10:5];
  assign new_seconds = s_axis_tdata[16:11];
  assign new_day     = s_axis_tdata[21:17];
  assign new_month   = s_axis_tdata[25:22];
  assign new_year    = s_axis_tdata[37:26];
  assign new_weekday = s_axis_tdata[40:38];

  // sunrise start: alarm 1 less the delay, modulo one day
  assign alarm_one_day = ({1'b0, alarm_one_minute} >= MINUTES_PER_DAY) ?
                         {1'b0, alarm_one_minute} - MINUTES_PER_DAY :
                         {1'b0, alarm_one_minute};
  assign start_raw     = alarm_one_day + MINUTES_PER_DAY - {5'd0, sunrise_delay};
  assign sunrise_start = (start_raw >= MINUTES_PER_DAY) ? start_raw - MINUTES_PER_DAY
                                                         : start_raw;

  // backlight fade step with ceiling then floor clamp
  assign fade_raw = fade_downward ?
                    $signed({2'b00, backlight_level}) - $signed({2'b00, fade_increment}) :
                    $signed({2'b00, backlight_level}) + $signed({2'b00, fade_increment});
  assign fade_hi  = (fade_raw > $signed({2'b00, backlight_ceiling})) ?
                    $signed({2'b00, backlight_ceiling}) : fade_raw;
  assign fade_lo  = (fade_hi < $signed({2'b00, backlight_floor})) ?
                    $signed({2'b00, backlight_floor}) : fade_hi;
  assign fade_stop = (fade_raw > $signed({2'b00, backlight_ceiling})) ||
                     (fade_hi < $signed({2'b00, backlight_floor}));

  assign tick_sum    = {1'b0, tick_count} + (TICK_W+1)'(1);
  assign sec_sum     = {1'b0, sec_reg} + 7'd1;
  assign min_sum     = {1'b0, min_reg} + 7'd1;
  assign hour_sum    = {1'b0, hour_reg} + 6'd1;
  assign day_sum     = {1'b0, day_reg} + 6'd1;
  assign month_sum   = {1'b0, month_reg} + 5'd1;
  assign sunrise_sum = sunrise_seconds + 7'd1;
  assign lamp_sum    = {1'b0, lamp_level} + (LAMP_W+1)'(1);

  // next state for one accepted item
  always_comb begin
    tick_count_next      = tick_count;
    sec_reg_next         = sec_reg;
    min_reg_next         = min_reg;
    hour_reg_next        = hour_reg;
    day_reg_next         = day_reg;
    month_reg_next       = month_reg;
    year_reg_next        = year_reg;
    weekday_reg_next     = weekday_reg;
    backlight_level_next = backlight_level;
    fade_running_next    = fade_running;
    fade_downward_next   = fade_downward;
    hold_seconds_next    = hold_seconds;
    lamp_level_next      = lamp_level;
    sunrise_running_next = sunrise_running;
    sunrise_seconds_next = sunrise_seconds;
    ring_active_next     = ring_active;
    snooze_active_next   = snooze_active;
    snooze_seconds_next  = snooze_seconds;
    now_minute           = 11'd0;

    if (in_fire) begin
      case (in_action)
        ACT_TICK: begin
          if (fade_running) begin
            backlight_level_next = fade_lo[5:0];
            if (fade_stop) begin
              fade_running_next = 1'b0;
            end
          end
          if (tick_sum >= TICK_LIMIT) begin
            tick_count_next = '0;
            sec_reg_next    = sec_sum[5:0];
            // sunrise lamp step
            if (sunrise_running) begin
              sunrise_seconds_next = sunrise_sum;
              if (sunrise_sum >= sunrise_delay) begin
                sunrise_seconds_next = 7'd0;
                if (lamp_sum > LAMP_TOP) begin
                  lamp_level_next      = LAMP_TOP[LAMP_W-1:0];
                  sunrise_running_next = 1'b0;
                end else begin
                  lamp_level_next = lamp_sum[LAMP_W-1:0];
                end
              end
            end
            // backlight hold countdown
            if (hold_seconds != '0) begin
              hold_seconds_next = hold_seconds - HOLD_W'(1);
              if (hold_seconds == HOLD_W'(1)) begin
                fade_running_next  = 1'b1;
                fade_downward_next = 1'b1;
              end
            end
            // snooze countdown
            if (snooze_active) begin
              snooze_seconds_next = snooze_seconds - 12'd1;
              if (snooze_seconds == 12'd1) begin
                snooze_active_next = 1'b0;
                ring_active_next   = 1'b1;
              end
            end
            // calendar carries
            if (sec_sum >= 7'd60) begin
              sec_reg_next = 6'd0;
              min_reg_next = min_sum[5:0];
              if (min_sum >= 7'd60) begin
                min_reg_next  = 6'd0;
                hour_reg_next = hour_sum[4:0];
                if (hour_sum >= 6'd24) begin
                  hour_reg_next    = 5'd0;
                  day_reg_next     = day_sum[4:0];
                  weekday_reg_next = (weekday_reg < 3'd6) ? weekday_reg + 3'd1 : 3'd0;
                  if (day_sum > {1'b0, days_in(month_reg)}) begin
                    day_reg_next   = 5'd1;
                    month_reg_next = month_sum[3:0];
                    if (month_sum >= 5'd13) begin
                      month_reg_next = 4'd1;
                      year_reg_next  = year_reg + 12'd1;
                    end
                  end
                end
              end
              // new minute compares
              now_minute = {6'd0, hour_reg_next} * 11'd60 + {5'd0, min_reg_next};
              if (enable_bits[EN_SUNRISE] && ({1'b0, now_minute} == sunrise_start)) begin
                sunrise_running_next = 1'b1;
              end
              if (enable_bits[EN_ALARM_ONE] && (now_minute == alarm_one_minute)) begin
                ring_active_next = 1'b1;
              end
              if (enable_bits[EN_ALARM_TWO] && (now_minute == alarm_two_minute)) begin
                ring_active_next = 1'b1;
              end
            end
          end else begin
            tick_count_next = tick_sum[TICK_W-1:0];
          end
        end
        ACT_BUTTON: begin
          if (hold_seconds == '0) begin
            if (ring_active) begin
              ring_active_next    = 1'b0;
              snooze_active_next  = 1'b1;
              snooze_seconds_next = snooze_length;
            end
            backlight_level_next = backlight_floor;
            fade_running_next    = 1'b1;
            fade_downward_next   = 1'b0;
          end
          hold_seconds_next = HOLD_LOAD;
        end
        ACT_SET_TIME: begin
          hour_reg_next    = new_hours;
          min_reg_next     = new_minutes;
          sec_reg_next     = new_seconds;
          day_reg_next     = new_day;
          month_reg_next   = new_month;
          year_reg_next    = new_year;
          weekday_reg_next = new_weekday;
        end
        ACT_LAMP_OFF: begin
          sunrise_running_next = 1'b0;
          lamp_level_next      = '0;
        end
        default: begin
          lamp_level_next = lamp_level;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_one_minute  <= 11'd0;
      alarm_two_minute  <= 11'd0;
      sunrise_delay     <= 7'd3;
      enable_bits       <= 3'd0;
      backlight_floor   <= 6'd20;
      backlight_ceiling <= 6'd63;
      fade_increment    <= 6'd1;
      snooze_length     <= 12'd300;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ALARM_ONE:   alarm_one_minute  <= cfg_wdata[10:0];
        REG_ALARM_TWO:   alarm_two_minute  <= cfg_wdata[10:0];
        REG_SUNRISE_DLY: sunrise_delay     <= cfg_wdata[6:0];
        REG_ENABLE:      enable_bits       <= cfg_wdata[2:0];
        REG_BL_FLOOR:    backlight_floor   <= cfg_wdata[5:0];
        REG_BL_CEILING:  backlight_ceiling <= cfg_wdata[5:0];
        REG_FADE_INC:    fade_increment    <= cfg_wdata[5:0];
        REG_SNOOZE_LEN:  snooze_length     <= cfg_wdata;
        default:         snooze_length     <= snooze_length;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      sec_reg         <= 6'd58;
      min_reg         <= 6'd59;
      hour_reg        <= 5'd23;
      day_reg         <= 5'd1;
      month_reg       <= 4'd1;
      year_reg        <= 12'd2012;
      weekday_reg     <= 3'd1;
      backlight_level <= 6'd0;
      fade_running    <= 1'b0;
      fade_downward   <= 1'b0;
      hold_seconds    <= '0;
      lamp_level      <= '0;
      sunrise_running <= 1'b0;
      sunrise_seconds <= 7'd0;
      ring_active     <= 1'b0;
      snooze_active   <= 1'b0;
      snooze_seconds  <= 12'd0;
    end else begin
      tick_count      <= tick_count_next;
      sec_reg         <= sec_reg_next;
      min_reg         <= min_reg_next;
      hour_reg        <= hour_reg_next;
      day_reg         <= day_reg_next;
      month_reg       <= month_reg_next;
      year_reg        <= year_reg_next;
      weekday_reg     <= weekday_reg_next;
      backlight_level <= backlight_level_next;
      fade_running    <= fade_running_next;
      fade_downward   <= fade_downward_next;
      hold_seconds    <= hold_seconds_next;
      lamp_level      <= lamp_level_next;
      sunrise_running <= sunrise_running_next;
      sunrise_seconds <= sunrise_seconds_next;
      ring_active     <= ring_active_next;
      snooze_active   <= snooze_active_next;
      snooze_seconds  <= snooze_seconds_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= OUT_W'({snooze_active_next, ring_active_next, lamp_level_next,
                              backlight_level_next, weekday_reg_next, year_reg_next,
                              month_reg_next, day_reg_next, sec_reg_next,
                              min_reg_next, hour_reg_next});
    end
  end

endmodule

`default_nettype wire
